/* rtl/cds_pkg.sv */
// ----------------------------------------------------------------------------
// cds_pkg: shared types, tables and helpers for the calendar date stepper
// Date record, derived-info record, item kinds and the Gregorian month tables.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 7;
    localparam int DAY_W   = 7;
    localparam int DOY_W   = 9;
    localparam int QTR_W   = 3;
    localparam int LEN_W   = 5;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1700;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd2000;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 7'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 7'd2;
    localparam logic [LEN_W-1:0]   FEB_LEAP   = 5'd29;

    // y / 25 as (y * 5243) >> 17, exact for every 14-bit y
    localparam logic [26:0] DIV25_MUL   = 27'd5243;
    localparam int          DIV25_SHIFT = 17;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_NEXT = 2'd1,
        KIND_PREV = 2'd2,
        KIND_READ = 2'd3
    } kind_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic              ok;
        logic              leap;
        logic [QTR_W-1:0]  quarter;
        logic [DOY_W-1:0]  day_of_year;
        logic [DOY_W-1:0]  days_left;
    } info_t;

    localparam logic [LEN_W-1:0] MONTH_DAYS [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // days in the months before this one, common year
    localparam logic [DOY_W-1:0] DOY_BASE [0:12] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic [QTR_W-1:0] QUARTER_OF [0:12] = '{
        3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
    };

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0]       prod;
        logic [9:0]        quo;
        logic [YEAR_W-1:0] rem;
        logic              div25;
        prod  = 27'(y) * DIV25_MUL;
        quo   = prod[DIV25_SHIFT +: 10];
        rem   = y - YEAR_W'({4'd0, quo} * 14'd25);
        div25 = (rem == '0);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic month_ok(input logic [MONTH_W-1:0] m);
        return (m != '0) && (m <= MONTH_DEC);
    endfunction

    // length of month m in a year with the given leap flag; zero for bad months
    function automatic logic [LEN_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [LEN_W-1:0] len;
        if (!month_ok(m))
            len = '0;
        else if ((m == MONTH_FEB) && leap)
            len = FEB_LEAP;
        else
            len = MONTH_DAYS[m[3:0]];
        return len;
    endfunction

    function automatic logic date_valid(input date_t d, input logic leap);
        return (d.year >= YEAR_MIN) && (d.year <= YEAR_MAX) && month_ok(d.month)
            && (d.day != '0) && (d.day <= DAY_W'(month_len(leap, d.month)));
    endfunction

endpackage

/* rtl/cds_step.sv */
// ----------------------------------------------------------------------------
// cds_step: next-date logic
// Load, step one day forward or back, or hold the stored date.
// ----------------------------------------------------------------------------
module cds_step
(
    input  cds_pkg::kind_t kind,
    input  cds_pkg::date_t load_date,
    input  cds_pkg::date_t cur_date,
    output cds_pkg::date_t next_date
);
    import cds_pkg::*;

    logic  cur_leap;
    logic  cur_ok;
    logic  last_day;
    date_t fwd;
    date_t bwd;

    assign cur_leap = is_leap(cur_date.year);
    assign cur_ok   = date_valid(cur_date, cur_leap);
    assign last_day = (cur_date.day == DAY_W'(month_len(cur_leap, cur_date.month)));

    always_comb
    begin
        fwd = cur_date;
        if (!last_day)
        begin
            fwd.day = cur_date.day + 1'b1;
        end
        else if (cur_date.month != MONTH_DEC)
        begin
            fwd.day   = DAY_W'(1);
            fwd.month = cur_date.month + 1'b1;
        end
        else
        begin
            fwd.day   = DAY_W'(1);
            fwd.month = MONTH_W'(1);
            fwd.year  = (cur_date.year == YEAR_MAX) ? '0 : cur_date.year + 1'b1;
        end
    end

    // back across a month edge: December keeps its length, other months use this year
    always_comb
    begin
        bwd = cur_date;
        if (cur_date.day != DAY_W'(1))
        begin
            bwd.day = cur_date.day - 1'b1;
        end
        else if (cur_date.month != MONTH_W'(1))
        begin
            bwd.month = cur_date.month - 1'b1;
            bwd.day   = DAY_W'(month_len(cur_leap, cur_date.month - 1'b1));
        end
        else
        begin
            bwd.month = MONTH_DEC;
            bwd.day   = DAY_W'(MONTH_DAYS[12]);
            bwd.year  = (cur_date.year == '0) ? YEAR_MAX : cur_date.year - 1'b1;
        end
    end

    always_comb
    begin
        unique case (kind)
            KIND_LOAD: next_date = load_date;
            KIND_NEXT: next_date = cur_ok ? fwd : cur_date;
            KIND_PREV: next_date = cur_ok ? bwd : cur_date;
            KIND_READ: next_date = cur_date;
            default:   next_date = cur_date;
        endcase
    end

endmodule

/* rtl/cds_info.sv */
// ----------------------------------------------------------------------------
// cds_info: derived date information
// Validity, leap flag, quarter, ordinal day and days left for one date.
// ----------------------------------------------------------------------------
module cds_info
(
    input  cds_pkg::date_t date,
    output cds_pkg::info_t info
);
    import cds_pkg::*;

    logic             leap;
    logic             ok;
    logic [3:0]       midx;
    logic [DOY_W-1:0] doy;
    logic [DOY_W-1:0] total;

    assign leap  = is_leap(date.year);
    assign ok    = date_valid(date, leap);
    assign midx  = ok ? date.month[3:0] : 4'd0;
    assign doy   = DOY_BASE[midx] + DOY_W'(date.day)
                 + DOY_W'(leap && (date.month > MONTH_FEB));
    assign total = leap ? 9'd366 : 9'd365;

    always_comb
    begin
        info.ok          = ok;
        info.leap        = leap;
        info.quarter     = ok ? QUARTER_OF[midx] : '0;
        info.day_of_year = ok ? doy : '0;
        info.days_left   = ok ? total - doy : '0;
    end

endmodule

/* rtl/calendar_date_stepper.sv */
// ----------------------------------------------------------------------------
// calendar_date_stepper: Gregorian date register with one-day stepping
// Loads, steps forward or back, or reads a stored date and reports its info.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: one beat per command. tuser carries the kind
//   (load, next day, previous day, read); tdata carries the date to load.
//   Master stream m_axis_*: one beat per command with the stored date after
//   the command and its derived info (validity, leap, quarter, day of year,
//   days left in the year).
//   The date register updates when a command is accepted; the info logic
//   reads it and fills the output register once that register can load.
//   Throughput: one command per cycle while m_axis_tready is high, set by
//   the date update loop through the next-date logic.
//   Reset: the date returns to 2000-01-01 and both stages empty.
//   Stall: while m_axis_tready is low the output register holds; one more
//   command is taken into the middle stage, then s_axis_tready drops until
//   the result beat drains.
//   Steps on an invalid date leave it unchanged; the year wraps at 9999.
// ----------------------------------------------------------------------------
module calendar_date_stepper
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    input  logic [31:0] s_axis_tdata,   // [13:0] year, [20:14] month, [27:21] day, rest zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [13:0] cur_year, [20:14] cur_month, [27:21] cur_day, [28] date_ok, [29] leap,
    // [32:30] quarter, [41:33] day_of_year, [50:42] days_left, rest zero
    output logic [55:0] m_axis_tdata
);
    import cds_pkg::*;

    date_t                 date_reg;
    date_t                 date_next;
    date_t                 load_date;
    logic                  pend_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    info_t                 info;
    logic                  out_load;
    logic                  in_beat;

    // Output register takes a new beat when empty or being drained
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !pend_reg || out_load;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign load_date.year  = s_axis_tdata[13:0];
    assign load_date.month = s_axis_tdata[20:14];
    assign load_date.day   = s_axis_tdata[27:21];

    cds_step u_step
    (
        .kind      (kind_t'(s_axis_tuser)),
        .load_date (load_date),
        .cur_date  (date_reg),
        .next_date (date_next)
    );

    // Info for the date held after the pending command
    cds_info u_info
    (
        .date (date_reg),
        .info (info)
    );

    // Date register: takes the next date on every accepted command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.year  <= YEAR_RESET;
            date_reg.month <= MONTH_W'(1);
            date_reg.day   <= DAY_W'(1);
            pend_reg       <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                date_reg <= date_next;
            end
            if (in_beat)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && pend_reg)
        begin
            out_data_reg <= {5'd0, info.days_left, info.day_of_year, info.quarter,
                             info.leap, info.ok, date_reg.day, date_reg.month,
                             date_reg.year};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
